FILE: hw/rtl/tdr_pkg.sv
package tdr_pkg;

  localparam int RingDepth  = 60;
  localparam int DelaySlots = 5;
  localparam int SlotW      = $clog2(RingDepth);
  localparam int AngleW     = 16;
  localparam int IdW        = 16;
  localparam int TickW      = 32;
  localparam int StampW     = 64;
  localparam int DelayW     = TickW + $clog2(DelaySlots + 1);
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTimedMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDelayUnit = CfgIdxW'(1);

  typedef struct packed {
    logic [AngleW-1:0] roll;
    logic [AngleW-1:0] heading;
    logic [AngleW-1:0] pitch;
  } angles_t;

  typedef struct packed {
    angles_t           ang;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic shift;     // every cell takes its lower neighbor
    logic wrap;      // cell 0 takes the tail instead of the pushed entry
    logic load_all;  // every cell takes the fill entry
  } chain_ctrl_t;

endpackage

FILE: hw/rtl/timestamped_delay_ring.sv
// Delayed angle ring built as a chain of shift cells, newest word in cell 0.
// Fixed mode: the word goes to ST_WRITE, which loads the result once its register is free.
// Timed mode: steps prep, threshold, scan and write, then back to idle, the only state that
//   takes a word; the scan rotates the whole chain once past one 64-bit compare at the tail.
// Result register lets the next input word be taken while a result waits.
// Reset (async, active low) clears the ring, tick total and target tracking.
module timestamped_delay_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tdr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [tdr_pkg::AngleW-1:0] target_roll_i,
  input  logic signed [tdr_pkg::AngleW-1:0] target_heading_i,
  input  logic signed [tdr_pkg::AngleW-1:0] target_pitch_i,
  input  logic [tdr_pkg::IdW-1:0]       target_id_i,
  input  logic [tdr_pkg::TickW-1:0]     elapsed_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tdr_pkg::AngleW-1:0] out_roll_o,
  output logic signed [tdr_pkg::AngleW-1:0] out_heading_o,
  output logic signed [tdr_pkg::AngleW-1:0] out_pitch_o
);
  import tdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_THRESH,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e             state_q;
  logic               mode_q;
  logic [TickW-1:0]   unit_q;
  angles_t            in_ang_q;
  logic [IdW-1:0]     id_q;
  logic [TickW-1:0]   elapsed_q;
  logic [StampW-1:0]  total_q;
  logic [IdW-1:0]     last_target_q;
  logic               timed_ready_q;
  logic [DelayW-1:0]  delay_q;
  logic [StampW-1:0]  thr_q;
  logic [SlotW-1:0]   cnt_q;
  angles_t            sel_q;
  angles_t            out_q;
  logic               out_valid_q;

  chain_ctrl_t        ctrl;
  entry_t             push;
  entry_t             fill;
  entry_t             tail;
  entry_t             tap;
  logic               need_fill;
  logic               out_free;
  logic               in_take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign need_fill   = !timed_ready_q || (last_target_q != id_q);

  assign fill.ang   = in_ang_q;
  assign fill.stamp = '0;
  assign push.ang   = in_ang_q;
  // fixed mode leaves the overwritten slot's stamp in place
  assign push.stamp = mode_q ? total_q : tail.stamp;

  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_PREP: begin
        ctrl.load_all = need_fill;
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        ctrl.wrap  = 1'b1;
      end
      ST_WRITE: begin
        ctrl.shift = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  tdr_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .push_i (push),
    .fill_i (fill),
    .tail_o (tail),
    .tap_o  (tap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= 1'b0;
      unit_q        <= TickW'(1);
      in_ang_q      <= '0;
      id_q          <= '0;
      elapsed_q     <= '0;
      total_q       <= '0;
      last_target_q <= '0;
      timed_ready_q <= 1'b0;
      delay_q       <= '0;
      thr_q         <= '0;
      cnt_q         <= '0;
      sel_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgTimedMode: mode_q <= cfg_data_i[0];
          CfgDelayUnit: unit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // in ST_WRITE the result register is reloaded below
      if (out_valid_q && out_ready_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            in_ang_q.roll    <= target_roll_i;
            in_ang_q.heading <= target_heading_i;
            in_ang_q.pitch   <= target_pitch_i;
            id_q             <= target_id_i;
            elapsed_q        <= elapsed_ticks_i;
            sel_q            <= tap.ang;
            state_q          <= mode_q ? ST_PREP : ST_WRITE;
          end
        end
        ST_PREP: begin
          if (need_fill) begin
            total_q       <= StampW'(elapsed_q);
            last_target_q <= id_q;
            timed_ready_q <= 1'b1;
          end else begin
            total_q <= total_q + StampW'(elapsed_q);
          end
          delay_q <= DelayW'(DelaySlots) * DelayW'(unit_q);
          state_q <= ST_THRESH;
        end
        ST_THRESH: begin
          thr_q   <= (total_q > StampW'(delay_q)) ? total_q - StampW'(delay_q) : '0;
          cnt_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // tail sees oldest first; the last hit is the newest qualifying word,
          // and the oldest word stands when nothing qualifies
          if ((cnt_q == '0) || (tail.stamp <= thr_q)) begin
            sel_q <= tail.ang;
          end
          if (cnt_q == SlotW'(RingDepth - 1)) begin
            state_q <= ST_WRITE;
          end else begin
            cnt_q <= cnt_q + SlotW'(1);
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            out_q       <= sel_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_roll_o    = signed'(out_q.roll);
  assign out_heading_o = signed'(out_q.heading);
  assign out_pitch_o   = signed'(out_q.pitch);

endmodule

FILE: hw/rtl/tdr_cell.sv
module tdr_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdr_pkg::chain_ctrl_t ctrl_i,
  input  tdr_pkg::entry_t      prev_i,
  input  tdr_pkg::entry_t      fill_i,
  output tdr_pkg::entry_t      entry_o
);
  import tdr_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (ctrl_i.load_all) begin
      entry_q <= fill_i;
    end else if (ctrl_i.shift) begin
      entry_q <= prev_i;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/tdr_chain.sv
module tdr_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdr_pkg::chain_ctrl_t ctrl_i,
  input  tdr_pkg::entry_t      push_i,
  input  tdr_pkg::entry_t      fill_i,
  output tdr_pkg::entry_t      tail_o,
  output tdr_pkg::entry_t      tap_o
);
  import tdr_pkg::*;

  // cell 0 holds the newest word, the last cell the oldest
  entry_t cells[RingDepth];
  entry_t head;

  assign head = ctrl_i.wrap ? cells[RingDepth-1] : push_i;

  for (genvar k = 0; k < RingDepth; k++) begin : g_cell
    if (k == 0) begin : g_first
      tdr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .prev_i  (head),
        .fill_i  (fill_i),
        .entry_o (cells[k])
      );
    end else begin : g_rest
      tdr_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl_i),
        .prev_i  (cells[k-1]),
        .fill_i  (fill_i),
        .entry_o (cells[k])
      );
    end
  end

  assign tail_o = cells[RingDepth-1];
  assign tap_o  = cells[DelaySlots-1];

endmodule

FILE: dv/tb_timestamped_delay_ring.sv
module tb_timestamped_delay_ring;
  import tdr_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 80;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgIdxW'(15);
  localparam logic [CfgIdxW-1:0] CfgGapIdx   = CfgIdxW'(2);

  typedef struct {
    logic [AngleW-1:0] roll;
    logic [AngleW-1:0] heading;
    logic [AngleW-1:0] pitch;
    logic [IdW-1:0]    id;
    logic [TickW-1:0]  elapsed;
  } pose_word_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic signed [AngleW-1:0] target_roll_i = '0;
  logic signed [AngleW-1:0] target_heading_i = '0;
  logic signed [AngleW-1:0] target_pitch_i = '0;
  logic [IdW-1:0] target_id_i = '0;
  logic [TickW-1:0] elapsed_ticks_i = '0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [AngleW-1:0] out_roll_o;
  logic signed [AngleW-1:0] out_heading_o;
  logic signed [AngleW-1:0] out_pitch_o;

  timestamped_delay_ring u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .target_roll_i   (target_roll_i),
    .target_heading_i(target_heading_i),
    .target_pitch_i  (target_pitch_i),
    .target_id_i     (target_id_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_roll_o      (out_roll_o),
    .out_heading_o   (out_heading_o),
    .out_pitch_o     (out_pitch_o)
  );

  // pending input words and delayed triples still owed by the ring
  pose_word_t pose_words_q[$];
  angles_t    delayed_angles_q[$];

  // shadow of the ring
  angles_t           ring_angles[RingDepth];
  logic [StampW-1:0] ring_stamps[RingDepth];
  logic [StampW-1:0] tick_sum;
  int unsigned       head_slot;
  logic [IdW-1:0]    followed_id;
  logic              followed_valid;
  logic              timed_sel;
  logic [TickW-1:0]  unit_ticks;

  int mismatches;
  int checked_words;
  int fixed_words;
  int timed_words;
  int refills;
  int fallbacks;
  int cycles;
  bit steady;

  function automatic angles_t step_delay_ring(pose_word_t w);
    angles_t           fresh;
    angles_t           taken;
    logic [StampW-1:0] delay;
    logic [StampW-1:0] floor_stamp;
    int unsigned       pick;
    bit                hit;
    fresh.roll    = w.roll;
    fresh.heading = w.heading;
    fresh.pitch   = w.pitch;
    pick = (head_slot + RingDepth - DelaySlots) % RingDepth;
    if (timed_sel) begin
      timed_words++;
      if (!followed_valid || followed_id != w.id) begin
        for (int i = 0; i < RingDepth; i++) begin
          ring_angles[i] = fresh;
          ring_stamps[i] = '0;
        end
        tick_sum       = '0;
        followed_id    = w.id;
        followed_valid = 1'b1;
        refills++;
      end
      tick_sum    = tick_sum + StampW'(w.elapsed);
      delay       = StampW'(DelaySlots) * StampW'(unit_ticks);
      floor_stamp = (tick_sum > delay) ? tick_sum - delay : '0;
      // newest first; if nothing is old enough we end on the oldest slot
      hit = 1'b0;
      for (int i = 1; i <= RingDepth && !hit; i++) begin
        pick = (head_slot + RingDepth - i) % RingDepth;
        hit  = (ring_stamps[pick] <= floor_stamp);
      end
      if (!hit) fallbacks++;
      ring_stamps[head_slot] = tick_sum;
    end else begin
      fixed_words++;
    end
    taken = ring_angles[pick];
    ring_angles[head_slot] = fresh;
    head_slot = (head_slot + 1) % RingDepth;
    return taken;
  endfunction

  task automatic note_mismatch(input string what, input logic [AngleW-1:0] want,
                               input logic [AngleW-1:0] got);
    if (mismatches < 40) begin
      $display("[%0d] mismatch on %s: expected %h, got %h", cycles, what, want, got);
    end
    mismatches++;
  endtask

  task automatic add_word(input logic [AngleW-1:0] r, input logic [AngleW-1:0] h,
                          input logic [AngleW-1:0] p, input logic [IdW-1:0] id,
                          input logic [TickW-1:0] el);
    pose_word_t w;
    w.roll    = r;
    w.heading = h;
    w.pitch   = p;
    w.id      = id;
    w.elapsed = el;
    pose_words_q.push_back(w);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgTimedMode: timed_sel = data[0];
      CfgDelayUnit: unit_ticks = data;
      default: ;
    endcase
  endtask

  // block is quiet once every word is in, every triple is back and input is open
  task automatic settle();
    do @(posedge clk_i);
    while (!(pose_words_q.size() == 0 && !in_valid_i && delayed_angles_q.size() == 0
             && in_ready_o));
  endtask

  task automatic set_mode(input logic mode, input logic [TickW-1:0] unit);
    settle();
    write_reg(CfgTimedMode, (CfgDataW'($urandom) & ~CfgDataW'(1)) | CfgDataW'(mode));
    write_reg(CfgDelayUnit, unit);
  endtask

  // runs of one target with random angles; a few stray ids break the runs
  task automatic queue_random_words(input int count, input logic [TickW-1:0] pace_max,
                                    input int wild_pct);
    logic [IdW-1:0]   run_id;
    logic [IdW-1:0]   id;
    logic [TickW-1:0] el;
    int               run_left;
    int               r;
    run_left = 0;
    run_id   = IdW'($urandom);
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(90, 1);
        case ($urandom_range(3))
          0: run_id = IdW'($urandom);
          1: run_id = run_id ^ IdW'(1);
          2: run_id = '1;
          default: run_id = '0;
        endcase
      end
      run_left--;
      id = ($urandom_range(99) < 8) ? IdW'($urandom) : run_id;
      r  = $urandom_range(99);
      if (r < wild_pct / 2)         el = '1;
      else if (r < wild_pct)        el = $urandom;
      else if (r < wild_pct + 10)   el = '0;
      else                          el = $urandom_range(pace_max);
      add_word(AngleW'($urandom), AngleW'($urandom), AngleW'($urandom), id, el);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles,
               delayed_angles_q.size());
      $display("timestamped_delay_ring verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : drive_words
    logic took;
    if (rst_ni) begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        delayed_angles_q.push_back(step_delay_ring(pose_words_q.pop_front()));
      end
      if (!in_valid_i || took) begin
        if (pose_words_q.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          in_valid_i       <= 1'b1;
          target_roll_i    <= pose_words_q[0].roll;
          target_heading_i <= pose_words_q[0].heading;
          target_pitch_i   <= pose_words_q[0].pitch;
          target_id_i      <= pose_words_q[0].id;
          elapsed_ticks_i  <= pose_words_q[0].elapsed;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= steady || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin : check_words
    angles_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (delayed_angles_q.size() == 0) begin
        note_mismatch("unexpected word", '0, out_roll_o);
      end else begin
        want = delayed_angles_q.pop_front();
        checked_words++;
        if (out_roll_o !== want.roll)       note_mismatch("roll", want.roll, out_roll_o);
        if (out_heading_o !== want.heading) note_mismatch("heading", want.heading, out_heading_o);
        if (out_pitch_o !== want.pitch)     note_mismatch("pitch", want.pitch, out_pitch_o);
      end
    end
  end

  initial begin : stimulus
    logic [TickW-1:0] unit;
    for (int i = 0; i < RingDepth; i++) begin
      ring_angles[i] = '0;
      ring_stamps[i] = '0;
    end
    tick_sum = '0;
    head_slot = 0;
    followed_id = '0;
    followed_valid = 1'b0;
    timed_sel = 1'b0;
    unit_ticks = TickW'(1);
    steady = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fixed delay straight out of reset: first five words come back as zero
    add_word(16'h7fff, 16'h8000, 16'hffff, 16'h0000, 32'h0);
    add_word(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 32'hffff_ffff);
    for (int i = 0; i < 6; i++) begin
      add_word(AngleW'($urandom), AngleW'($urandom), AngleW'($urandom), IdW'($urandom),
               $urandom);
    end
    settle();
    // writes to indexes with no register behind them must change nothing
    write_reg(CfgSpareIdx, 32'hffff_ffff);
    write_reg(CfgGapIdx, 32'h0000_0000);
    write_reg(CfgTimedMode, 32'hffff_ffff);
    write_reg(CfgDelayUnit, 32'd3);

    // first use refills, then short history, then a real threshold, then a new target
    add_word(16'h1111, 16'h2222, 16'h3333, 16'h1234, 32'd2);
    for (int i = 0; i < 4; i++) begin
      add_word(AngleW'($urandom), AngleW'($urandom), AngleW'($urandom), 16'h1234, 32'd1);
    end
    add_word(16'h4444, 16'h5555, 16'h6666, 16'h1234, 32'd20);
    add_word(16'h8000, 16'h7fff, 16'h0001, 16'hffff, 32'h0);
    add_word(16'h0001, 16'hfffe, 16'h8000, 16'hffff, 32'hffff_ffff);
    settle();
    write_reg(CfgDelayUnit, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) begin
      add_word(AngleW'($urandom), AngleW'($urandom), AngleW'($urandom), 16'hffff,
               32'hffff_ffff);
    end
    add_word(16'h0f0f, 16'hf0f0, 16'h5a5a, 16'hffff, 32'h0);
    settle();
    write_reg(CfgDelayUnit, 32'h0);
    add_word(16'h1357, 16'h2468, 16'h9bdf, 16'hffff, 32'd5);
    add_word(16'hace0, 16'hbdf1, 16'h0246, 16'hffff, 32'd0);

    // random phases over the register settings
    steady = 1'b1;
    set_mode(1'b1, 32'd1);
    queue_random_words(250, 32'd3, 10);
    settle();
    steady = 1'b0;

    unit = $urandom_range(5000, 2);
    set_mode(1'b1, unit);
    queue_random_words(250, 2 * unit, 10);

    unit = $urandom;
    set_mode(1'b0, unit);
    queue_random_words(250, 32'd100, 20);

    // huge delay with tiny steps: only zero-stamped slots such as refilled ones qualify, else the oldest slot wins
    set_mode(1'b1, 32'hffff_ffff);
    queue_random_words(250, 32'd1000, 0);

    set_mode(1'b1, 32'hffff_ffff);
    queue_random_words(250, 32'hffff_ffff, 20);

    set_mode(1'b1, 32'h0);
    queue_random_words(250, 32'd100, 10);

    unit = $urandom;
    set_mode(1'b1, unit);
    queue_random_words(250, $urandom, 20);

    set_mode(1'b0, 32'd1);
    queue_random_words(250, 32'd100, 20);

    settle();
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d delayed words: %0d fixed delay, %0d timestamp search",
             checked_words, fixed_words, timed_words);
    $display("timed path saw %0d ring refills and %0d oldest-slot fallbacks",
             refills, fallbacks);
    if (mismatches == 0 && delayed_angles_q.size() == 0) begin
      $display("timestamped_delay_ring verification clean");
    end else begin
      $display("timestamped_delay_ring verification failed");
    end
    $finish;
  end

endmodule
